[src/bbr_pkg.sv]
// Shared types and constants for the bracket balance repair block.
// Used by bbr_ctrl, bbr_dp and the top level; depends on nothing.
package bbr_pkg;

  localparam int ClassW = 3;
  localparam int TagW   = 16;
  localparam int KindW  = 2;

  localparam logic [ClassW-1:0] CLS_OTHER   = 3'd0;
  localparam logic [ClassW-1:0] CLS_OPEN_P  = 3'd1;
  localparam logic [ClassW-1:0] CLS_OPEN_B  = 3'd3;
  localparam logic [ClassW-1:0] CLS_CLOSE_P = 3'd4;
  localparam logic [ClassW-1:0] CLS_CLOSE_B = 3'd6;
  localparam logic [ClassW-1:0] CLS_OFFSET  = 3'd3;

  localparam logic ACT_TOKEN = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // source of the next result item
  typedef enum logic [1:0] {
    OSEL_INPUT  = 2'd0,
    OSEL_HELD   = 2'd1,
    OSEL_INSERT = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     push;
    logic     pop;
    logic     rd_top;
    logic     rd_below;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     out_ovf;
  } cmd_t;

  typedef struct packed {
    logic in_flush;
    logic in_open;
    logic in_close;
    logic count_zero;
    logic count_one;
    logic stack_full;
    logic top_match;
    logic held_flush;
    logic out_free;
  } sts_t;

endpackage

[src/bbr_ctrl.sv]
// Controller for bracket balance repair: accepts items and sequences pops.
// Depends on bbr_pkg; drives bbr_dp through cmd_t, watches sts_t.
module bbr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bbr_pkg::sts_t sts,
  output bbr_pkg::cmd_t cmd
);
  import bbr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TEST = 3'b010,
    S_PASS = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = !((state_r == S_IDLE) && sts.out_free);

  always_comb begin
    cmd       = '0;
    cmd.out_sel = OSEL_INPUT;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.out_free) begin
          if (sts.in_flush || sts.in_close) begin
            if (!sts.count_zero) begin
              cmd.load_item = 1'b1;
              cmd.rd_top    = 1'b1;
              state_nxt     = S_TEST;
            end else if (sts.in_close) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
            // flush with empty stack yields nothing
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            if (sts.in_open) begin
              cmd.push    = !sts.stack_full;
              cmd.out_ovf = sts.stack_full;
            end
          end
        end
      end
      S_TEST: begin
        if (sts.out_free) begin
          cmd.pop      = 1'b1;
          cmd.out_load = 1'b1;
          if (!sts.held_flush && sts.top_match) begin
            cmd.out_sel  = OSEL_HELD;
            cmd.out_last = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.out_sel = OSEL_INSERT;
            if (sts.count_one) begin
              cmd.out_last = sts.held_flush;
              state_nxt    = sts.held_flush ? S_IDLE : S_PASS;
            end else begin
              cmd.rd_below = 1'b1;
            end
          end
        end
      end
      S_PASS: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_HELD;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/bbr_dp.sv]
// Datapath for bracket balance repair: opener stack memory, count,
// held item and output register. Depends on bbr_pkg.
module bbr_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_action,
  input  logic [bbr_pkg::ClassW-1:0] in_token_class,
  input  logic [bbr_pkg::TagW-1:0]   in_token_tag,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [bbr_pkg::ClassW-1:0] out_class,
  output logic [bbr_pkg::TagW-1:0]   out_tag,
  output logic                       out_inserted,
  output logic                       out_overflow,
  output logic                       out_last,
  input  bbr_pkg::cmd_t              cmd,
  output bbr_pkg::sts_t              sts
);
  import bbr_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [KindW-1:0]  stack_mem [STACK_DEPTH];
  logic [KindW-1:0]  rd_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_cnt;
  logic              held_flush_r;
  logic [ClassW-1:0] held_class_r;
  logic [TagW-1:0]   held_tag_r;
  logic [ClassW-1:0] want;
  logic              out_valid_r;
  logic [ClassW-1:0] out_class_r;
  logic [TagW-1:0]   out_tag_r;
  logic              out_ins_r, out_ovf_r, out_last_r;

  assign want = held_class_r - CLS_OFFSET;

  assign sts.in_flush   = (in_action == ACT_FLUSH);
  assign sts.in_open    = (in_action == ACT_TOKEN) && (in_token_class >= CLS_OPEN_P)
                          && (in_token_class <= CLS_OPEN_B);
  assign sts.in_close   = (in_action == ACT_TOKEN) && (in_token_class >= CLS_CLOSE_P)
                          && (in_token_class <= CLS_CLOSE_B);
  assign sts.count_zero = (count_r == '0);
  assign sts.count_one  = (count_r == CW'(1));
  assign sts.stack_full = (count_r == CW'(STACK_DEPTH));
  assign sts.top_match  = (rd_r == want[KindW-1:0]);
  assign sts.held_flush = held_flush_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign count_nxt = cmd.push ? count_r + CW'(1) :
                     cmd.pop  ? count_r - CW'(1) : count_r;

  // top entry sits at count-1; after a pop the next one is at count-2
  assign rd_cnt = cmd.rd_below ? count_r - CW'(2) : count_r - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[count_r[AW-1:0]] <= in_token_class[KindW-1:0];
    end
    if (cmd.rd_top || cmd.rd_below) begin
      rd_r <= stack_mem[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      held_flush_r <= in_action;
      held_class_r <= in_token_class;
      held_tag_r   <= in_token_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      out_ovf_r  <= cmd.out_ovf;
      case (cmd.out_sel)
        OSEL_INPUT: begin
          out_class_r <= in_token_class;
          out_tag_r   <= in_token_tag;
          out_ins_r   <= 1'b0;
        end
        OSEL_HELD: begin
          out_class_r <= held_class_r;
          out_tag_r   <= held_tag_r;
          out_ins_r   <= 1'b0;
        end
        OSEL_INSERT: begin
          out_class_r <= {1'b0, rd_r} + CLS_OFFSET;
          out_tag_r   <= '0;
          out_ins_r   <= 1'b1;
        end
        default: begin
          out_class_r <= CLS_OTHER;
          out_tag_r   <= '0;
          out_ins_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_class    = out_class_r;
  assign out_tag      = out_tag_r;
  assign out_inserted = out_ins_r;
  assign out_overflow = out_ovf_r;
  assign out_last     = out_last_r;

endmodule

[src/bracket_balance_repair_core.sv]
// Top level of the bracket balance repair block.
// Instantiates bbr_ctrl and bbr_dp; depends on bbr_pkg.
//
// Usage:
//   Input channel in_*: one token item (in_action = 0) or an end-of-stream
//   flush (in_action = 1) per accepted item. Output channel out_*: repaired
//   tokens; out_last marks the final result caused by an input item.
//   Both channels: accepted when valid is high and stall is low.
// Throughput:
//   Other tokens, openers, closers on an empty stack: one item per cycle
//   while the output is not stalled.
//   Closers and flushes on a non-empty stack: the stack read first, then
//   N results (N <= depth+1), one per cycle while the output is not stalled.
//   The stack memory's read port is registered.
// Reset: rst_n (synchronous, active low) empties the stack and drops any
//   pending result; stack contents are not cleared.
// Stall: a stalled result holds in the output register; the block raises
//   in_stall until that slot frees up.
module bracket_balance_repair_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [bbr_pkg::ClassW-1:0] in_token_class,
  input  logic [bbr_pkg::TagW-1:0]   in_token_tag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bbr_pkg::ClassW-1:0] out_class,
  output logic [bbr_pkg::TagW-1:0]   out_tag,
  output logic                       out_inserted,
  output logic                       out_overflow,
  output logic                       out_last
);
  import bbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbr_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_token_class (in_token_class),
    .in_token_tag   (in_token_tag),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_class      (out_class),
    .out_tag        (out_tag),
    .out_inserted   (out_inserted),
    .out_overflow   (out_overflow),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

[src/bbr_chk.sv]
// Port-level checker for bracket balance repair, bound to the top level.
// Depends on bbr_pkg for class codes.
module bbr_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bbr_pkg::ClassW-1:0] out_class,
  input logic [bbr_pkg::TagW-1:0]   out_tag,
  input logic                       out_inserted,
  input logic                       out_overflow,
  input logic                       out_last
);
  import bbr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_class) && $stable(out_tag))
    else $error("stalled result changed");

  a_insert_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inserted |-> (out_tag == '0) && !out_overflow
      && (out_class >= CLS_CLOSE_P) && (out_class <= CLS_CLOSE_B))
    else $error("inserted item is not a tagless closer");

  a_ovf_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_inserted && out_last
      && (out_class >= CLS_OPEN_P) && (out_class <= CLS_OPEN_B))
    else $error("overflow on something other than a lone opener");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bracket_balance_repair_core bbr_chk u_bbr_chk (.*);

[sim/testbench.sv]
// Self-checking bench for bracket_balance_repair_core: random bursts of tokens,
// a bracket-stack predictor and an in-order result check. Depends on bbr_pkg.
`timescale 1ns / 1ps

import bbr_pkg::*;

typedef struct packed {
  logic [ClassW-1:0] cls;
  logic [TagW-1:0]   tag;
  logic              ins;
  logic              ovf;
  logic              last;
} repair_result_t;

// Tracks the open-bracket stack and the tokens the block still owes.
class repair_tracker;
  int depth;
  logic [KindW-1:0] open_kinds [64];
  int open_count;
  repair_result_t owed[$];
  int noted, matched, errors, closers_added, overflows;

  function new(int d);
    depth = d;
    open_count = 0;
    noted = 0;
    matched = 0;
    errors = 0;
    closers_added = 0;
    overflows = 0;
  endfunction

  function void owe(logic [ClassW-1:0] c, logic [TagW-1:0] t, logic i, logic o);
    repair_result_t r;
    r.cls = c;
    r.tag = t;
    r.ins = i;
    r.ovf = o;
    r.last = 1'b0;
    owed.push_back(r);
    if (i) closers_added++;
    if (o) overflows++;
  endfunction

  function void take_token(logic act, logic [ClassW-1:0] cls, logic [TagW-1:0] tag);
    int start_len;
    logic [ClassW-1:0] want;
    repair_result_t r;
    start_len = owed.size();
    noted++;
    if (act == ACT_FLUSH) begin
      while (open_count > 0) begin
        open_count--;
        owe({1'b0, open_kinds[open_count]} + CLS_OFFSET, '0, 1'b1, 1'b0);
      end
    end else if (cls >= CLS_OPEN_P && cls <= CLS_OPEN_B) begin
      if (open_count < depth) begin
        open_kinds[open_count] = cls[KindW-1:0];
        open_count++;
        owe(cls, tag, 1'b0, 1'b0);
      end else begin
        owe(cls, tag, 1'b0, 1'b1);
      end
    end else if (cls >= CLS_CLOSE_P && cls <= CLS_CLOSE_B) begin
      want = cls - CLS_OFFSET;
      // close every opener of another kind sitting above the match, or all if none matches
      while (open_count > 0 && {1'b0, open_kinds[open_count-1]} != want) begin
        open_count--;
        owe({1'b0, open_kinds[open_count]} + CLS_OFFSET, '0, 1'b1, 1'b0);
      end
      if (open_count > 0) open_count--;
      owe(cls, tag, 1'b0, 1'b0);
    end else begin
      owe(cls, tag, 1'b0, 1'b0);
    end
    if (owed.size() > start_len) begin
      r = owed.pop_back();
      r.last = 1'b1;
      owed.push_back(r);
    end
  endfunction

  function void match_emitted(repair_result_t got);
    repair_result_t exp;
    matched++;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result class %0d tag %h ins %b ovf %b last %b",
                 $realtime, got.cls, got.tag, got.ins, got.ovf, got.last);
      return;
    end
    exp = owed.pop_front();
    if (got.cls !== exp.cls || got.tag !== exp.tag || got.ins !== exp.ins ||
        got.ovf !== exp.ovf || got.last !== exp.last) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: result %0d exp cls %0d tag %h ins %b ovf %b last %b",
                 $realtime, matched, exp.cls, exp.tag, exp.ins, exp.ovf, exp.last);
        $display("    got cls %0d tag %h ins %b ovf %b last %b",
                 got.cls, got.tag, got.ins, got.ovf, got.last);
      end
    end
  endfunction
endclass

module testbench;

  localparam int Depth = 32;
  localparam int TokenTarget = 470;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 2 * Depth + 8;

  localparam logic [ClassW-1:0] OpenBrace   = 3'd2;
  localparam logic [ClassW-1:0] CloseBrace  = 3'd5;
  localparam logic [ClassW-1:0] ClassUnused = 3'd7;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_action = ACT_TOKEN;
  logic [ClassW-1:0] in_token_class = CLS_OTHER;
  logic [TagW-1:0]   in_token_tag = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ClassW-1:0] out_class;
  logic [TagW-1:0]   out_tag;
  logic              out_inserted;
  logic              out_overflow;
  logic              out_last;

  repair_tracker tracker;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [KindW-1:0] nest[$];

  bracket_balance_repair_core #(
    .STACK_DEPTH(Depth)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_token_class(in_token_class),
    .in_token_tag  (in_token_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_class     (out_class),
    .out_tag       (out_tag),
    .out_inserted  (out_inserted),
    .out_overflow  (out_overflow),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [TagW-1:0] rand_tag();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return TagW'($urandom_range(0, 65535));
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic feed_token(logic act, logic [ClassW-1:0] cls, logic [TagW-1:0] tag);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_token_class <= cls;
    in_token_tag <= tag;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      if (took) tracker.take_token(act, cls, tag);
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Mostly balanced nesting, with a few closers of the wrong kind.
  task automatic feed_nested(int len);
    int r;
    logic [KindW-1:0] k;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (nest.size() < 36 && r < 45) begin
        k = KindW'($urandom_range(1, 3));
        nest.push_back(k);
        feed_token(ACT_TOKEN, {1'b0, k}, rand_tag());
      end else if (nest.size() > 0 && r < 80) begin
        k = nest.pop_back();
        if ($urandom_range(0, 9) == 0) k = KindW'((k % 3) + 1);
        feed_token(ACT_TOKEN, {1'b0, k} + CLS_OFFSET, rand_tag());
      end else begin
        feed_token(ACT_TOKEN, ($urandom_range(0, 4) == 0) ? ClassUnused : CLS_OTHER,
                   rand_tag());
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      feed_token(ACT_FLUSH, ClassW'($urandom_range(0, 7)), rand_tag());
      nest.delete();
    end
  endtask

  // Feeds n openers (full stack once n >= depth), then a flush or a closer not of kind k to unwind it.
  task automatic feed_deep(int n, bit one_kind);
    logic [KindW-1:0] k;
    k = KindW'($urandom_range(1, 3));
    for (int i = 0; i < n; i++)
      feed_token(ACT_TOKEN, one_kind ? {1'b0, k} : ClassW'($urandom_range(1, 3)), rand_tag());
    if ($urandom_range(0, 2) == 0)
      feed_token(ACT_FLUSH, ClassW'($urandom_range(0, 7)), rand_tag());
    else
      feed_token(ACT_TOKEN, {1'b0, KindW'((k % 3) + 1)} + CLS_OFFSET, rand_tag());
    nest.delete();
  endtask

  // receiver: switches between free flow, random, periodic and heavy stall
  initial begin
    int mode;
    int phase;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk);
        phase++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 35);
          2: out_stall <= (phase % 3 != 0);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  initial begin
    repair_result_t got;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.cls = out_class;
        got.tag = out_tag;
        got.ins = out_inserted;
        got.ovf = out_overflow;
        got.last = out_last;
        tracker.match_emitted(got);
      end
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: %0d cycles without progress", WatchdogLimit);
    $display("bracket_balance_repair_core: mismatch");
    $finish;
  end

  initial begin
    int pick;
    tracker = new(Depth);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    feed_token(ACT_TOKEN, CLS_OTHER, 16'h0000);
    feed_token(ACT_TOKEN, CLS_OTHER, 16'hFFFF);
    feed_token(ACT_TOKEN, ClassUnused, 16'h1234);
    feed_token(ACT_FLUSH, CloseBrace, 16'hABCD);   // empty stack: nothing out
    feed_token(ACT_TOKEN, CLS_CLOSE_P, 16'h0001);  // unmatched closer
    feed_token(ACT_TOKEN, CLS_OPEN_P, 16'h0010);
    feed_token(ACT_TOKEN, OpenBrace, 16'h0011);
    feed_token(ACT_TOKEN, CLS_OPEN_B, 16'h0012);
    feed_token(ACT_TOKEN, CLS_CLOSE_B, 16'h0013);
    feed_token(ACT_TOKEN, CLS_CLOSE_P, 16'h0014);  // repairs the brace first
    feed_token(ACT_TOKEN, CLS_OPEN_B, 16'h0015);
    feed_token(ACT_TOKEN, OpenBrace, 16'h0016);
    feed_token(ACT_TOKEN, CloseBrace, 16'h0017);
    feed_token(ACT_TOKEN, CLS_CLOSE_P, 16'h0018);  // pops all, then unmatched
    feed_token(ACT_TOKEN, CLS_OPEN_P, 16'h0019);
    feed_token(ACT_TOKEN, CLS_OPEN_B, 16'h0020);
    feed_token(ACT_TOKEN, OpenBrace, 16'h0021);
    feed_token(ACT_FLUSH, CLS_OPEN_B, 16'hFFFF);   // fields ignored on flush
    feed_token(ACT_TOKEN, CLS_CLOSE_B, 16'h0022);
    feed_token(ACT_TOKEN, CloseBrace, 16'h0023);
    feed_token(ACT_TOKEN, CLS_OPEN_P, 16'h8000);
    feed_token(ACT_FLUSH, CLS_OTHER, 16'h0000);

    // full stack and overflow, then the longest repair run
    feed_deep(Depth + 2, 1'b1);

    while (items_sent < TokenTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        feed_nested($urandom_range(4, 24));
      end else if (pick < 63) begin
        feed_deep($urandom_range(Depth - 4, Depth + 4), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 8))
          feed_token(($urandom_range(0, 7) == 0) ? ACT_FLUSH : ACT_TOKEN,
                     ClassW'($urandom_range(0, 7)), rand_tag());
      end
    end
    in_valid <= 1'b0;

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d tokens and flushes, %0d results checked", tracker.noted,
             tracker.matched);
    $display("of those, %0d repair closers and %0d stack-full openers", tracker.closers_added,
             tracker.overflows);
    if (tracker.errors == 0 && tracker.owed.size() == 0)
      $display("bracket_balance_repair_core: match");
    else
      $display("bracket_balance_repair_core: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/bbr_pkg.sv
src/bbr_ctrl.sv
src/bbr_dp.sv
src/bracket_balance_repair_core.sv
src/bbr_chk.sv
sim/testbench.sv
